/* sv/etc_pkg.sv */
// ----------------------------------------------------------------------------
// etc_pkg
// shared types, constants and calendar tables for the epoch to date converter
// ----------------------------------------------------------------------------
`default_nettype none

package etc_pkg;

  localparam int unsigned OffW      = 17;
  localparam int unsigned TdataInW  = 32;
  localparam int unsigned TdataOutW = 56;
  localparam int unsigned BaseYear  = 1970;

  localparam logic [OffW-1:0] OffsetReset = 17'h1B9B0;  // -18000

  // 2^37 / 60 rounded up, exact for 32-bit dividends
  localparam logic [31:0] Recip60 = 32'h8888_8889;
  // 2^33 / 3 rounded up
  localparam logic [31:0] Recip3  = 32'hAAAA_AAAB;
  // 2^19 / 7 rounded up, exact for 16-bit dividends
  localparam logic [16:0] Recip7  = 17'd74899;
  // 2^20 / 365 rounded up, year estimate never low and at most one high
  localparam logic [11:0] Recip365 = 12'd2873;

  // year offset of 2100, the only skipped leap year in range
  localparam logic [7:0] Off2100 = 8'd130;

  typedef struct packed {
    logic [15:0] days;
    logic [12:0] week_q;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
  } time_t;

  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [2:0]  weekday;
    logic [4:0]  day_of_month;
    logic [3:0]  month;
    logic [11:0] year;
    logic [8:0]  ordinal_day;
    logic        leap_year;
  } date_t;

  localparam logic [2:0] WdOfMod7 [7] = '{3'd4, 3'd5, 3'd6, 3'd0, 3'd1, 3'd2, 3'd3};

  // days before each month in a common year
  localparam logic [8:0] CumStart [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  function automatic logic is_leap_off(input logic [7:0] off);
    is_leap_off = (off[1:0] == 2'd2) && (off != Off2100);
  endfunction

  function automatic logic [8:0] cum_start(input logic [3:0] m, input logic leap);
    logic [8:0] c;
    c = CumStart[m];
    if (leap && (m >= 4'd2)) begin
      c = c + 9'd1;
    end
    cum_start = c;
  endfunction

endpackage

`default_nettype wire

/* sv/etc_time.sv */
// ----------------------------------------------------------------------------
// etc_time
// offset add and constant divisions into second, minute, hour and day count
// ----------------------------------------------------------------------------
`default_nettype none

module etc_time (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      en_i,
  input  wire logic                      vld_i,
  input  wire logic [31:0]               epoch_i,
  input  wire logic [etc_pkg::OffW-1:0]  offset_i,
  output logic                           vld_o,
  output etc_pkg::time_t                 time_o
);
  import etc_pkg::*;

  logic [7:0]  vld_q;
  logic [31:0] t1_q, t2_q, t3_q;
  logic [26:0] q1_q, q1b_q, q1c_q;
  logic [20:0] q2_q, q2b_q, q2c_q;
  logic [5:0]  sec3_q, sec4_q, sec5_q, sec6_q, sec7_q;
  logic [5:0]  min5_q, min6_q, min7_q;
  logic [15:0] days6_q, days7_q;
  logic [4:0]  hour7_q;
  logic [12:0] wq7_q;

  logic [63:0] p1, p2;
  logic [50:0] p3;
  logic [32:0] p4;
  logic [31:0] t1_d;

  assign t1_d = epoch_i + {{(32-OffW){offset_i[OffW-1]}}, offset_i};
  assign p1   = t2_q * Recip60;
  assign p2   = {5'd0, q1b_q} * Recip60;
  assign p3   = {q2b_q[20:3]} * Recip3;
  assign p4   = days6_q * Recip7;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[6:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_q    <= t1_d;
      t2_q    <= t1_q;
      t3_q    <= t2_q;
      q1_q    <= p1[63:37];
      sec3_q  <= 6'(t3_q - 32'(q1_q) * 32'd60);
      q1b_q   <= q1_q;
      q1c_q   <= q1b_q;
      q2_q    <= p2[57:37];
      sec4_q  <= sec3_q;
      sec5_q  <= sec4_q;
      min5_q  <= 6'(q1c_q - 27'(q2_q) * 27'd60);
      q2b_q   <= q2_q;
      q2c_q   <= q2b_q;
      days6_q <= p3[48:33];
      sec6_q  <= sec5_q;
      min6_q  <= min5_q;
      days7_q <= days6_q;
      hour7_q <= 5'(q2c_q - 21'(days6_q) * 21'd24);
      wq7_q   <= p4[31:19];
      sec7_q  <= sec6_q;
      min7_q  <= min6_q;
    end
  end

  // stage alignment: t3/q1 feed sec3, q1c/q2 feed min5, q2c/days6 feed hour7
  assign vld_o         = vld_q[7];
  assign time_o.days   = days7_q;
  assign time_o.week_q = wq7_q;
  assign time_o.second = sec7_q;
  assign time_o.minute = min7_q;
  assign time_o.hour   = hour7_q;

endmodule

`default_nettype wire

/* sv/etc_date.sv */
// ----------------------------------------------------------------------------
// etc_date
// weekday, year estimate and correction, month search and day of month
// ----------------------------------------------------------------------------
`default_nettype none

module etc_date (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           vld_i,
  input  etc_pkg::time_t      time_i,
  output logic                vld_o,
  output etc_pkg::date_t      date_o
);
  import etc_pkg::*;

  logic [4:0]  vld_q;
  time_t       t1_q, t2_q, t3_q, t4_q, t5_q;
  logic [2:0]  wd1_q, wd2_q, wd3_q, wd4_q, wd5_q;
  logic [7:0]  e1_q, e2_q, o3_q, o4_q;
  logic [15:0] start2_q;
  logic [8:0]  doy3_q, doy4_q, doy5_q;
  logic        leap3_q, leap4_q, leap5_q;
  logic [3:0]  m4_q;
  logic [3:0]  m5_q;
  logic [4:0]  dom5_q;
  logic [11:0] year5_q;

  logic [27:0] pe;
  logic [15:0] wrem;
  logic [7:0]  o3_d;
  logic [15:0] start3;
  logic        low;
  logic [3:0]  m_d;

  assign pe   = time_i.days * Recip365;
  assign wrem = time_i.days - 16'(time_i.week_q) * 16'd7;
  assign low  = t2_q.days < start2_q;
  assign o3_d = low ? e2_q - 8'd1 : e2_q;
  assign start3 = low ? start2_q - (is_leap_off(o3_d) ? 16'd366 : 16'd365) : start2_q;

  always_comb begin
    m_d = '0;
    for (int k = 1; k < 12; k++) begin
      if (doy3_q > cum_start(4'(k), leap3_q)) begin
        m_d = 4'(k);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_q     <= time_i;
      wd1_q    <= WdOfMod7[wrem[2:0]];
      e1_q     <= pe[27:20];
      t2_q     <= t1_q;
      wd2_q    <= wd1_q;
      e2_q     <= e1_q;
      start2_q <= 16'(e1_q * 16'd365) + 16'((e1_q + 8'd1) >> 2)
                  - ((e1_q > Off2100) ? 16'd1 : 16'd0);
      t3_q     <= t2_q;
      wd3_q    <= wd2_q;
      o3_q     <= o3_d;
      doy3_q   <= 9'(t2_q.days - start3) + 9'd1;
      leap3_q  <= is_leap_off(o3_d);
      t4_q     <= t3_q;
      wd4_q    <= wd3_q;
      o4_q     <= o3_q;
      doy4_q   <= doy3_q;
      leap4_q  <= leap3_q;
      m4_q     <= m_d;
      t5_q     <= t4_q;
      wd5_q    <= wd4_q;
      doy5_q   <= doy4_q;
      leap5_q  <= leap4_q;
      dom5_q   <= 5'(doy4_q - cum_start(m4_q, leap4_q));
      year5_q  <= 12'(BaseYear) + {4'd0, o4_q};
      m5_q     <= m4_q + 4'd1;
    end
  end

  // note: leap years before 1970 + e counted as (e + 1) / 4, less one past 2100
  assign vld_o               = vld_q[4];
  assign date_o.second       = t5_q.second;
  assign date_o.minute       = t5_q.minute;
  assign date_o.hour         = t5_q.hour;
  assign date_o.weekday      = wd5_q;
  assign date_o.day_of_month = dom5_q;
  assign date_o.month        = m5_q;
  assign date_o.year         = year5_q;
  assign date_o.ordinal_day  = doy5_q;
  assign date_o.leap_year    = leap5_q;

endmodule

`default_nettype wire

/* sv/epoch_to_calendar_date.sv */
// ----------------------------------------------------------------------------
// epoch_to_calendar_date
// unix seconds plus a signed zone offset to a gregorian date and time of day
// ----------------------------------------------------------------------------
// input words arrive on s_axis: tdata carries the 32-bit epoch second count.
// each word gives exactly one output word on m_axis with second, minute,
// hour, weekday, day of month, month, year, day of year and a leap flag.
// the zone offset register is written through cfg_we_i / cfg_wdata_i and is
// added to every word with wrap modulo 2^32; it resets to -18000 seconds.
// the datapath is a 13-stage pipeline plus an output register, and one word
// is taken every cycle while the receiver keeps up. the constant multiplies
// of the divide chain and the year correction set the stage count.
// when m_axis_tready is low and the output register is full, the whole
// pipeline holds and s_axis_tready drops; no word is lost or repeated.
// reset empties the pipeline and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module epoch_to_calendar_date (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [etc_pkg::OffW-1:0]        cfg_wdata_i,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [etc_pkg::TdataInW-1:0]    s_axis_tdata,  // epoch_seconds
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // second, minute, hour, weekday, day_of_month, month, year, ordinal_day, leap_year
  output logic [etc_pkg::TdataOutW-1:0]        m_axis_tdata
);
  import etc_pkg::*;

  logic [OffW-1:0] offset_q;
  logic            en;
  logic            tvld;
  time_t           tm;
  logic            dvld;
  date_t           dt;
  logic            out_vld_q;
  date_t           out_q;

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= OffsetReset;
    end else if (cfg_we_i) begin
      offset_q <= cfg_wdata_i;
    end
  end

  etc_time u_time (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .vld_i    (s_axis_tvalid),
    .epoch_i  (s_axis_tdata),
    .offset_i (offset_q),
    .vld_o    (tvld),
    .time_o   (tm)
  );

  etc_date u_date (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (tvld),
    .time_i (tm),
    .vld_o  (dvld),
    .date_o (dt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dvld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= dt;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'd0, out_q.leap_year, out_q.ordinal_day, out_q.year,
                          out_q.month, out_q.day_of_month, out_q.weekday,
                          out_q.hour, out_q.minute, out_q.second};

endmodule

`default_nettype wire
